[src/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants for the quadratic root solver
// Item classes, queue status and output format constants.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // Output root format: signed Q16.16
    localparam int FRAC_OUT = 16;
    localparam int ROOT_W   = 32;

    // Class of an item, decided in the front part
    typedef enum logic [1:0] {
        KIND_QUAD,   // a nonzero, discriminant not negative
        KIND_LIN,    // a zero, b nonzero
        KIND_ZERO,   // all coefficients zero
        KIND_NONE    // no real solution
    } kind_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

[src/qrs_front.sv]
// ----------------------------------------------------------------------------
// qrs_front: input stage of the quadratic root solver
// Takes coefficients, forms b*b and |a*c|, the discriminant and the class.
// ----------------------------------------------------------------------------
module qrs_front #(
    parameter int CW = 16,
    parameter int DW = 2 * CW + 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CW-1:0]           in_a,
    input  logic [CW-1:0]           in_b,
    input  logic [CW-1:0]           in_c,
    input  qrs_pkg::fifo_stat_t     stat,
    output logic                    push,
    output logic [CW-1:0]           out_a,
    output logic [CW-1:0]           out_b,
    output logic [CW-1:0]           out_c,
    output logic [DW-1:0]           out_disc,
    output qrs_pkg::kind_t          out_kind
);

    logic            en;
    logic [CW-1:0]   mag_a, mag_b, mag_c;

    // stage 1
    logic            v1_reg;
    logic [CW-1:0]   a1_reg, b1_reg, c1_reg;
    logic [2*CW-1:0] bb1_reg, ac1_reg;
    logic            acpos1_reg;

    // stage 2
    logic            v2_reg;
    logic [CW-1:0]   a2_reg, b2_reg, c2_reg;
    logic [DW-1:0]   d2_reg;
    qrs_pkg::kind_t  k2_reg;

    logic [DW-1:0]   fl, bbx;
    logic            neg_disc;
    qrs_pkg::kind_t  kind_next;

    // advance unless the last stage holds an item the queue cannot take
    assign en       = !(v2_reg && stat.full);
    assign in_ready = en;
    assign push     = v2_reg && en;

    assign mag_a = in_a[CW-1] ? (~in_a + 1'b1) : in_a;
    assign mag_b = in_b[CW-1] ? (~in_b + 1'b1) : in_b;
    assign mag_c = in_c[CW-1] ? (~in_c + 1'b1) : in_c;

    // discriminant and class
    always_comb begin
        fl       = {ac1_reg, 2'b00};
        bbx      = {2'b00, bb1_reg};
        neg_disc = acpos1_reg && (fl > bbx);
        if (a1_reg == '0) begin
            if (b1_reg != '0) begin
                kind_next = qrs_pkg::KIND_LIN;
            end else if (c1_reg == '0) begin
                kind_next = qrs_pkg::KIND_ZERO;
            end else begin
                kind_next = qrs_pkg::KIND_NONE;
            end
        end else if (neg_disc) begin
            kind_next = qrs_pkg::KIND_NONE;
        end else begin
            kind_next = qrs_pkg::KIND_QUAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            a1_reg     <= in_a;
            b1_reg     <= in_b;
            c1_reg     <= in_c;
            bb1_reg    <= mag_b * mag_b;
            ac1_reg    <= mag_a * mag_c;
            acpos1_reg <= (in_a[CW-1] == in_c[CW-1]) && (in_c != '0);
            a2_reg     <= a1_reg;
            b2_reg     <= b1_reg;
            c2_reg     <= c1_reg;
            d2_reg     <= acpos1_reg ? (bbx - fl) : (bbx + fl);
            k2_reg     <= kind_next;
        end
    end

    assign out_a    = a2_reg;
    assign out_b    = b2_reg;
    assign out_c    = c2_reg;
    assign out_disc = d2_reg;
    assign out_kind = k2_reg;

endmodule

[src/qrs_fifo.sv]
// ----------------------------------------------------------------------------
// qrs_fifo: two-entry queue between front and back parts
// Registered entries, registered status.
// ----------------------------------------------------------------------------
module qrs_fifo #(
    parameter int W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic [W-1:0]        wdata,
    input  logic                pop,
    output logic [W-1:0]        rdata,
    output qrs_pkg::fifo_stat_t stat
);

    logic [W-1:0] mem_reg [0:1];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg, cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    assign rdata      = mem_reg[rp_reg];
    assign stat.full  = cnt_reg[1];
    assign stat.empty = (cnt_reg == 2'd0);

    // queue depth and pointer agreement
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count beyond depth");
    a_ptr_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) == (wp_reg != rp_reg)) else $error("queue pointers out of step");

endmodule

[src/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div: pipelined restoring divider, unsigned magnitudes
// One quotient bit per stage, each stage advancing only while en is high.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int QW  = 35,
    parameter int DVW = 17
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [QW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic [QW-1:0]  quotient
);

    logic [QW-1:0]  dvd_reg [0:QW];
    logic [DVW-1:0] rem_reg [0:QW];
    logic [DVW-1:0] dv_reg  [0:QW];

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd_reg[0] <= dividend;
            rem_reg[0] <= '0;
            dv_reg[0]  <= divisor;
        end
    end

    // one bit per stage; dividend shifts out as quotient shifts in
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DVW:0] rsh;
        logic [DVW:0] rsub;
        logic         ge;
        assign rsh  = {rem_reg[k], dvd_reg[k][QW-1]};
        assign ge   = rsh >= {1'b0, dv_reg[k]};
        assign rsub = rsh - {1'b0, dv_reg[k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? rsub[DVW-1:0] : rsh[DVW-1:0];
                dvd_reg[k+1] <= {dvd_reg[k][QW-2:0], ge};
                dv_reg[k+1]  <= dv_reg[k];
            end
        end
    end

    assign quotient = dvd_reg[QW];

endmodule

[src/qrs_back.sv]
// ----------------------------------------------------------------------------
// qrs_back: execution part of the quadratic root solver
// Pipelined square root, two pipelined dividers, sign and Q16.16 clipping.
// ----------------------------------------------------------------------------
module qrs_back #(
    parameter int CW = 16,
    parameter int DW = 2 * CW + 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  qrs_pkg::fifo_stat_t          stat,
    output logic                         pop,
    input  logic [CW-1:0]                in_a,
    input  logic [CW-1:0]                in_b,
    input  logic [CW-1:0]                in_c,
    input  logic [DW-1:0]                in_disc,
    input  qrs_pkg::kind_t               in_kind,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_solvable,
    output logic                         out_saturated,
    output logic [qrs_pkg::ROOT_W-1:0]   out_root_plus,
    output logic [qrs_pkg::ROOT_W-1:0]   out_root_minus
);

    localparam int SW  = CW + 1;              // root bits
    localparam int RW  = SW + 2;              // sqrt remainder bits
    localparam int NW  = CW + 3;              // signed numerator bits
    localparam int DVW = CW + 1;              // divisor magnitude bits
    localparam int QW  = NW + qrs_pkg::FRAC_OUT;
    localparam int LW  = (QW + 1 > 33) ? QW + 1 : 33;
    localparam logic signed [LW-1:0] MAXV = {{(LW-32){1'b0}}, 32'h7fffffff};
    localparam logic signed [LW-1:0] MINV = {{(LW-32){1'b1}}, 32'h80000000};

    logic en;

    // square root pipeline with passengers
    logic [RW-1:0]  sq_rem_reg  [0:SW];
    logic [SW-1:0]  sq_root_reg [0:SW];
    logic [DW-1:0]  sq_rad_reg  [0:SW];
    logic [CW-1:0]  sq_a_reg    [0:SW];
    logic [CW-1:0]  sq_b_reg    [0:SW];
    logic [CW-1:0]  sq_c_reg    [0:SW];
    qrs_pkg::kind_t sq_k_reg    [0:SW];
    logic           sq_v_reg    [0:SW];

    assign en  = !out_valid || out_ready;
    assign pop = en && !stat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= !stat.empty;
        end
        if (en) begin
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= in_disc;
            sq_a_reg[0]    <= in_a;
            sq_b_reg[0]    <= in_b;
            sq_c_reg[0]    <= in_c;
            sq_k_reg[0]    <= in_kind;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        logic [RW-1:0] rsh, trial, rsub;
        logic          ge;
        assign rsh   = {sq_rem_reg[k][RW-3:0], sq_rad_reg[k][DW-1:DW-2]};
        assign trial = {sq_root_reg[k], 2'b01};
        assign ge    = rsh >= trial;
        assign rsub  = rsh - trial;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
            if (en) begin
                sq_rem_reg[k+1]  <= ge ? rsub : rsh;
                sq_root_reg[k+1] <= {sq_root_reg[k][SW-2:0], ge};
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][DW-3:0], 2'b00};
                sq_a_reg[k+1]    <= sq_a_reg[k];
                sq_b_reg[k+1]    <= sq_b_reg[k];
                sq_c_reg[k+1]    <= sq_c_reg[k];
                sq_k_reg[k+1]    <= sq_k_reg[k];
            end
        end
    end

    // numerators, divisor and quotient signs
    logic signed [NW-1:0] ax, bx, cx, sx, np, nm;
    logic [NW-1:0]        mp, mm;
    logic [DVW-1:0]       dvs;
    logic                 sgn_p, sgn_m;
    logic [CW-1:0]        mag_a, mag_b;

    always_comb begin
        ax    = {{(NW-CW){sq_a_reg[SW][CW-1]}}, sq_a_reg[SW]};
        bx    = {{(NW-CW){sq_b_reg[SW][CW-1]}}, sq_b_reg[SW]};
        cx    = {{(NW-CW){sq_c_reg[SW][CW-1]}}, sq_c_reg[SW]};
        sx    = {{(NW-SW){1'b0}}, sq_root_reg[SW]};
        mag_a = ax[CW-1:0];
        mag_b = bx[CW-1:0];
        if (ax[NW-1]) mag_a = -ax[CW-1:0];
        if (bx[NW-1]) mag_b = -bx[CW-1:0];
        if (sq_k_reg[SW] == qrs_pkg::KIND_LIN) begin
            np    = -cx;
            nm    = -cx;
            dvs   = {1'b0, mag_b};
            sgn_p = np[NW-1] ^ bx[NW-1];
            sgn_m = sgn_p;
        end else begin
            np    = -bx + sx;
            nm    = -bx - sx;
            dvs   = {mag_a, 1'b0};
            sgn_p = np[NW-1] ^ ax[NW-1];
            sgn_m = nm[NW-1] ^ ax[NW-1];
        end
        mp = np[NW-1] ? NW'(-np) : NW'(np);
        mm = nm[NW-1] ? NW'(-nm) : NW'(nm);
    end

    logic [QW-1:0]  qp, qm;
    logic           dv_v_reg [0:QW];
    qrs_pkg::kind_t dv_k_reg [0:QW];
    logic           dv_sp_reg [0:QW];
    logic           dv_sm_reg [0:QW];

    qrs_div #(.QW(QW), .DVW(DVW)) u_div_p (
        .aclk     (aclk),
        .en       (en),
        .dividend ({mp, {qrs_pkg::FRAC_OUT{1'b0}}}),
        .divisor  (dvs),
        .quotient (qp)
    );

    qrs_div #(.QW(QW), .DVW(DVW)) u_div_m (
        .aclk     (aclk),
        .en       (en),
        .dividend ({mm, {qrs_pkg::FRAC_OUT{1'b0}}}),
        .divisor  (dvs),
        .quotient (qm)
    );

    // class and signs ride alongside the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= sq_v_reg[SW];
        end
        if (en) begin
            dv_k_reg[0]  <= sq_k_reg[SW];
            dv_sp_reg[0] <= sgn_p;
            dv_sm_reg[0] <= sgn_m;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_pass
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
            if (en) begin
                dv_k_reg[k+1]  <= dv_k_reg[k];
                dv_sp_reg[k+1] <= dv_sp_reg[k];
                dv_sm_reg[k+1] <= dv_sm_reg[k];
            end
        end
    end

    // apply sign and clip to Q16.16
    logic signed [LW-1:0] vp, vm;
    logic                 cp_hi, cp_lo, cm_hi, cm_lo;
    logic                 solv_next, sat_next;
    logic [31:0]          rp_next, rm_next;

    always_comb begin
        vp    = dv_sp_reg[QW] ? -$signed(LW'(qp)) : $signed(LW'(qp));
        vm    = dv_sm_reg[QW] ? -$signed(LW'(qm)) : $signed(LW'(qm));
        cp_hi = vp > MAXV;
        cp_lo = vp < MINV;
        cm_hi = vm > MAXV;
        cm_lo = vm < MINV;
        rp_next = cp_hi ? MAXV[31:0] : (cp_lo ? MINV[31:0] : vp[31:0]);
        rm_next = cm_hi ? MAXV[31:0] : (cm_lo ? MINV[31:0] : vm[31:0]);
        sat_next  = cp_hi || cp_lo || cm_hi || cm_lo;
        solv_next = 1'b1;
        case (dv_k_reg[QW])
            qrs_pkg::KIND_QUAD, qrs_pkg::KIND_LIN: begin
            end
            qrs_pkg::KIND_ZERO: begin
                rp_next  = '0;
                rm_next  = '0;
                sat_next = 1'b0;
            end
            default: begin
                rp_next   = '0;
                rm_next   = '0;
                sat_next  = 1'b0;
                solv_next = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= dv_v_reg[QW];
        end
        if (en) begin
            out_root_plus  <= rp_next;
            out_root_minus <= rm_next;
            out_saturated  <= sat_next;
            out_solvable   <= solv_next;
        end
    end

    a_unsolv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_solvable |-> out_root_plus == '0 && out_root_minus == '0
        && !out_saturated) else $error("unsolvable result carries data");
    a_lin_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        en && dv_v_reg[QW] && dv_k_reg[QW] == qrs_pkg::KIND_LIN |=>
        out_root_plus == out_root_minus) else $error("linear roots differ");

endmodule

[src/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2+b*x+c=0 in Q16.16
// Pipeline: front stages, two-entry queue, the one-bit-per-stage square root
// (COEF_WIDTH+1 stages), two one-bit-per-stage dividers (COEF_WIDTH+19 stages)
// and an output register.
// Throughput: one transaction per cycle when the output is not stalled by m_axis_tready.
// Reset: synchronous active-low aresetn clears all valid bits and the queue.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_axis_tdata: coef_quad, coef_lin, coef_const (low bits up), zero padded
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // m_axis_tdata: root_plus[31:0], root_minus[63:32]
    output logic [63:0]                           m_axis_tdata,
    // m_axis_tuser: solvable[0], saturated[1]
    output logic [1:0]                            m_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready
);

    localparam int CW = COEF_WIDTH;
    localparam int DW = 2 * CW + 2;
    localparam int IW = 3 * CW + DW + 2;

    qrs_pkg::fifo_stat_t stat;
    logic                push, pop;
    logic [CW-1:0]       f_a, f_b, f_c;
    logic [DW-1:0]       f_disc;
    qrs_pkg::kind_t      f_kind;
    logic [IW-1:0]       q_rd;

    qrs_front #(.CW(CW), .DW(DW)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_a     (s_axis_tdata[CW-1:0]),
        .in_b     (s_axis_tdata[2*CW-1:CW]),
        .in_c     (s_axis_tdata[3*CW-1:2*CW]),
        .stat     (stat),
        .push     (push),
        .out_a    (f_a),
        .out_b    (f_b),
        .out_c    (f_c),
        .out_disc (f_disc),
        .out_kind (f_kind)
    );

    qrs_fifo #(.W(IW)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   ({f_kind, f_disc, f_c, f_b, f_a}),
        .pop     (pop),
        .rdata   (q_rd),
        .stat    (stat)
    );

    qrs_back #(.CW(CW), .DW(DW)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .stat           (stat),
        .pop            (pop),
        .in_a           (q_rd[CW-1:0]),
        .in_b           (q_rd[2*CW-1:CW]),
        .in_c           (q_rd[3*CW-1:2*CW]),
        .in_disc        (q_rd[3*CW+DW-1:3*CW]),
        .in_kind        (qrs_pkg::kind_t'(q_rd[IW-1:IW-2])),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_solvable   (m_axis_tuser[0]),
        .out_saturated  (m_axis_tuser[1]),
        .out_root_plus  (m_axis_tdata[31:0]),
        .out_root_minus (m_axis_tdata[63:32])
    );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the quadratic root solver
// Drives random and directed coefficient sets through the input stream and
// checks every root transaction against an in-bench root predictor.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 16;
    localparam int DW        = ((3*CW+7)/8)*8;
    localparam int LATENCY   = 2*CW+27;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic        solvable;
        logic        saturated;
        logic [31:0] root_plus;
        logic [31:0] root_minus;
    } roots_t;

    logic          aclk;
    logic          aresetn;
    logic [DW-1:0] s_axis_tdata;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [63:0]   m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;

    quadratic_root_solver #(.COEF_WIDTH(CW)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
    );

    logic [DW-1:0] coef_q[$];
    roots_t        roots_q[$];
    int            src_idle_pct;
    int            snk_idle_pct;
    bit            hold_src;
    int            n_fail;
    int            n_roots;
    int            n_sat;
    int            n_unsolv;
    int            idle_cnt;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Clip a quotient to Q16.16, flagging saturation
    function automatic logic [31:0] clip_root(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // Root prediction for one coefficient set
    function automatic roots_t solve_roots(input logic signed [CW-1:0] qa,
                                           input logic signed [CW-1:0] qb,
                                           input logic signed [CW-1:0] qc);
        roots_t          r;
        logic signed [71:0] disc;
        logic [71:0]     s;
        logic [71:0]     t;
        longint          a, b, c, den, np, nm;
        logic            sat;
        a = qa; b = qb; c = qc;
        r = '0;
        sat = 1'b0;
        if (a == 0) begin
            if (b != 0) begin
                r.solvable   = 1'b1;
                r.root_plus  = clip_root((-c * 65536) / b, sat);
                r.root_minus = r.root_plus;
                r.saturated  = sat;
            end else if (c == 0) begin
                r.solvable = 1'b1;
            end
            return r;
        end
        disc = 72'(b) * 72'(b) - 72'sd4 * 72'(a) * 72'(c);
        if (disc < 0) return r;
        // bitwise floor square root, 34 result bits
        s = '0;
        for (int i = 33; i >= 0; i--) begin
            t = s | (72'd1 << i);
            if (t * t <= 72'(disc)) s = t;
        end
        den = 2 * a;
        np = -b + longint'(s);
        nm = -b - longint'(s);
        r.solvable   = 1'b1;
        r.root_plus  = clip_root((np * 65536) / den, sat);
        r.root_minus = clip_root((nm * 65536) / den, sat);
        r.saturated  = sat;
        return r;
    endfunction

    function automatic logic [DW-1:0] pack_coef(input logic [CW-1:0] qa,
                                                input logic [CW-1:0] qb,
                                                input logic [CW-1:0] qc);
        logic [DW-1:0] d;
        d = '0;
        d[CW-1:0]      = qa;
        d[2*CW-1:CW]   = qb;
        d[3*CW-1:2*CW] = qc;
        return d;
    endfunction

    // Random coefficient, biased toward small and edge values
    function automatic logic [CW-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'h7fff;
            2:       return 16'h8000;
            3, 4:    return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Driver: offer next pending set, idling at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (coef_q.size() > 0 && !hold_src &&
                $urandom_range(0, 99) >= src_idle_pct) begin
                s_axis_tdata  <= coef_q[0];
                s_axis_tvalid <= 1'b1;
                roots_q.push_back(solve_roots(coef_q[0][CW-1:0],
                                  coef_q[0][2*CW-1:CW], coef_q[0][3*CW-1:2*CW]));
                coef_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else          m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Monitor: compare each root transaction with the oldest prediction
    always @(posedge aclk) begin
        roots_t exp_r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (roots_q.size() == 0) begin
                $error("unexpected result transaction");
                n_fail++;
            end else begin
                exp_r = roots_q.pop_front();
                n_roots++;
                if (exp_r.saturated) n_sat++;
                if (!exp_r.solvable) n_unsolv++;
                if (m_axis_tuser[0] !== exp_r.solvable) begin
                    $error("solvable exp %0d got %0d", exp_r.solvable, m_axis_tuser[0]);
                    n_fail++;
                end
                if (m_axis_tuser[1] !== exp_r.saturated) begin
                    $error("saturated exp %0d got %0d", exp_r.saturated, m_axis_tuser[1]);
                    n_fail++;
                end
                if (m_axis_tdata[31:0] !== exp_r.root_plus) begin
                    $error("root_plus exp %h got %h", exp_r.root_plus, m_axis_tdata[31:0]);
                    n_fail++;
                end
                if (m_axis_tdata[63:32] !== exp_r.root_minus) begin
                    $error("root_minus exp %h got %h", exp_r.root_minus,
                           m_axis_tdata[63:32]);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WDOG_MAX) begin
                $display("watchdog: no transaction for %0d cycles", WDOG_MAX);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic fill_random(input int n);
        logic [CW-1:0] qa, qb, qc;
        for (int i = 0; i < n; i++) begin
            qa = rand_coef(); qb = rand_coef(); qc = rand_coef();
            if ($urandom_range(0, 7) == 0) qa = '0;
            coef_q.push_back(pack_coef(qa, qb, qc));
        end
    endtask

    task automatic drain();
        while (coef_q.size() > 0 || s_axis_tvalid || roots_q.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        hold_src = 1'b0;
        src_idle_pct = 37;
        snk_idle_pct = 69;
        n_fail = 0; n_roots = 0; n_sat = 0; n_unsolv = 0; idle_cnt = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: each class of equation and the coefficient extremes
        coef_q.push_back(pack_coef(16'h0000, 16'h0000, 16'h0000)); // all zero
        coef_q.push_back(pack_coef(16'h0000, 16'h0000, 16'h0100)); // constant only
        coef_q.push_back(pack_coef(16'h0000, 16'h0100, 16'h0200)); // linear
        coef_q.push_back(pack_coef(16'h0000, 16'h0001, 16'h7fff)); // linear, root -32767, no saturation
        coef_q.push_back(pack_coef(16'h0000, 16'h0001, 16'h8000)); // linear, saturates
        coef_q.push_back(pack_coef(16'h0000, 16'hffff, 16'h8000));
        coef_q.push_back(pack_coef(16'h0100, 16'h0000, 16'h0100)); // negative disc
        coef_q.push_back(pack_coef(16'h0100, 16'h0000, 16'hff00)); // roots +-1
        coef_q.push_back(pack_coef(16'h0100, 16'hfe00, 16'h0100)); // double root
        coef_q.push_back(pack_coef(16'h0001, 16'h7fff, 16'h0000)); // roots 0 and -32767
        coef_q.push_back(pack_coef(16'h7fff, 16'h7fff, 16'h7fff));
        coef_q.push_back(pack_coef(16'h8000, 16'h8000, 16'h8000));
        coef_q.push_back(pack_coef(16'h8000, 16'h8000, 16'h7fff)); // widest disc
        coef_q.push_back(pack_coef(16'h7fff, 16'h8000, 16'h8000));
        coef_q.push_back(pack_coef(16'hffff, 16'h0000, 16'hffff)); // negative disc
        coef_q.push_back(pack_coef(16'hffff, 16'hffff, 16'h0001));
        coef_q.push_back(pack_coef(16'h0001, 16'h0000, 16'h0000));
        coef_q.push_back(pack_coef(16'h0001, 16'h0001, 16'hffff));
        fill_random(420);
        drain();

        // Sender held for a pause after every root is in, then idling swapped
        hold_src = 1'b1;
        repeat (LATENCY + 10) @(posedge aclk);
        hold_src = 1'b0;
        src_idle_pct = 69;
        snk_idle_pct = 37;
        fill_random(430);
        drain();

        // No idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        fill_random(430);
        drain();

        repeat (LATENCY + 20) @(posedge aclk);
        $display("covered %0d coefficient sets: %0d unsolvable, %0d saturated",
                 n_roots, n_unsolv, n_sat);
        $display("three idling phases plus a full drain pause on the sender");
        if (n_fail == 0 && roots_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[filelist.f]
src/qrs_pkg.sv
src/qrs_front.sv
src/qrs_fifo.sv
src/qrs_div.sv
src/qrs_back.sv
src/quadratic_root_solver.sv
tb/tb_top.sv
